### rtl/core/dnsrp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnsrp_pkg
// Types and constants shared by the DNS A-record response parser modules.
// ----------------------------------------------------------------------------
package dnsrp_pkg;

	// header and record layout
	localparam logic [3:0]  HEADER_BYTES      = 4'd12;
	localparam logic [3:0]  FIXED_BYTES       = 4'd10;
	localparam logic [3:0]  QFIXED_BYTES      = 4'd4;
	localparam logic [3:0]  ADDR_BYTES        = 4'd4;
	localparam logic [7:0]  PTR_MASK          = 8'hC0;
	localparam logic [15:0] TYPE_A            = 16'd1;
	localparam logic [15:0] ADDR_RDLENGTH     = 16'd4;
	localparam int          FLAG_QR_BIT       = 15;
	localparam logic [15:0] EXPECTED_ID_RESET = 16'h1234;

	// header byte offsets that carry fields
	localparam logic [3:0] OFS_ID_HI   = 4'd0;
	localparam logic [3:0] OFS_ID_LO   = 4'd1;
	localparam logic [3:0] OFS_FLG_HI  = 4'd2;
	localparam logic [3:0] OFS_FLG_LO  = 4'd3;
	localparam logic [3:0] OFS_ANC_HI  = 4'd6;
	localparam logic [3:0] OFS_ANC_LO  = 4'd7;

	// record fixed-part byte offsets
	localparam logic [3:0] OFS_TYPE_HI = 4'd0;
	localparam logic [3:0] OFS_TYPE_LO = 4'd1;
	localparam logic [3:0] OFS_RDL_HI  = 4'd8;
	localparam logic [3:0] OFS_RDL_LO  = 4'd9;

	// result status codes
	localparam logic [2:0] ST_RESOLVED   = 3'd0;
	localparam logic [2:0] ST_IGNORED    = 3'd1;
	localparam logic [2:0] ST_SERVER_ERR = 3'd2;
	localparam logic [2:0] ST_NO_ANSWERS = 3'd3;
	localparam logic [2:0] ST_NO_ADDRESS = 3'd4;

	typedef enum logic [3:0] {
		PH_HEADER = 4'd0,
		PH_QNAME  = 4'd1,
		PH_QLABEL = 4'd2,
		PH_QPTR   = 4'd3,
		PH_QFIXED = 4'd4,
		PH_ANAME  = 4'd5,
		PH_ALABEL = 4'd6,
		PH_APTR   = 4'd7,
		PH_AFIXED = 4'd8,
		PH_RSKIP  = 4'd9,
		PH_RADDR  = 4'd10,
		PH_DONE   = 4'd11
	} phase_t;

	typedef struct packed {
		logic [7:0] packet_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  error_code;
		logic [31:0] address;
	} result_t;

	// handoff from the parser to the result register
	typedef struct packed {
		logic    load;
		result_t data;
	} result_push_t;

endpackage : dnsrp_pkg
`default_nettype wire

### rtl/core/dns_response_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dns_response_parser_unit
// DNS A-record response parser: one packet byte per transaction in, one
// verdict per packet out.
// ----------------------------------------------------------------------------
// The unit takes one byte per clock while not stalled and gives one result
// transaction per packet: the packet's last byte is
// registered, the parse state is updated by a single pass of logic, and the
// verdict lands in an output register. Input is stalled only when a last
// byte is waiting and the output register still holds a result that the
// receiver has not taken; all other bytes flow every cycle. The expected
// transaction ID is written through cfg_wr_en/cfg_wr_data while no packet
// is in flight (the user must keep to this; the block does not enforce it) and resets to 0x1234.
module dns_response_parser_unit import dnsrp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire item_t       item,
	output logic             result_valid,
	input  wire logic        result_stall,
	output result_t          result
);

	logic         valid_s1;
	item_t        item_s1;
	logic [15:0]  expected_id_q;
	logic         out_free;
	logic         go;
	result_push_t push;

	// a staged byte moves on unless it closes a packet and the output is full
	assign go         = !item_s1.last_byte || out_free;
	assign item_stall = valid_s1 && !go;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_id_q <= EXPECTED_ID_RESET;
		end else if (cfg_wr_en) begin
			expected_id_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall) begin
			item_s1 <= item;
		end
	end

	// parse state and verdict
	dnsrp_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (valid_s1 && go),
		.item_s1     (item_s1),
		.expected_id (expected_id_q),
		.push        (push)
	);

	// result register
	dnsrp_result_reg u_result_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.free         (out_free)
	);

endmodule : dns_response_parser_unit
`default_nettype wire

### rtl/core/dnsrp_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnsrp_parser
// Per-packet parse state and the single-byte update; forms the verdict when
// the last byte of a packet goes through.
// ----------------------------------------------------------------------------
module dnsrp_parser import dnsrp_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         fire,
	input  wire item_t        item_s1,
	input  wire logic [15:0]  expected_id,
	output result_push_t      push
);

	phase_t      phase_q, phase_d;
	logic [3:0]  field_offset_q, field_offset_d;
	logic [15:0] header_id_q, header_id_d;
	logic [15:0] header_flags_q, header_flags_d;
	logic [15:0] answers_left_q, answers_left_d;
	logic [15:0] skip_count_q, skip_count_d;
	logic [15:0] record_type_q, record_type_d;
	logic [15:0] record_length_q, record_length_d;
	logic [31:0] address_shift_q, address_shift_d;
	logic        found_q, found_d;

	logic [7:0]  b;
	logic [15:0] skip_dec;
	logic [15:0] record_length_new;
	logic        is_question;

	assign b        = item_s1.packet_byte;
	assign skip_dec = skip_count_q - 16'd1;

	// byte update
	always_comb begin
		phase_d         = phase_q;
		field_offset_d  = field_offset_q;
		header_id_d     = header_id_q;
		header_flags_d  = header_flags_q;
		answers_left_d  = answers_left_q;
		skip_count_d    = skip_count_q;
		record_type_d   = record_type_q;
		record_length_d = record_length_q;
		address_shift_d = address_shift_q;
		found_d         = found_q;
		is_question     = (phase_q == PH_QNAME);
		record_length_new = record_length_q;

		case (phase_q)
			PH_HEADER: begin
				case (field_offset_q)
					OFS_ID_HI:  header_id_d    = {b, 8'h00};
					OFS_ID_LO:  header_id_d    = header_id_q | {8'h00, b};
					OFS_FLG_HI: header_flags_d = {b, 8'h00};
					OFS_FLG_LO: header_flags_d = header_flags_q | {8'h00, b};
					OFS_ANC_HI: answers_left_d = {b, 8'h00};
					OFS_ANC_LO: answers_left_d = answers_left_q | {8'h00, b};
					default: ;
				endcase
				if (field_offset_q == HEADER_BYTES - 4'd1) begin
					field_offset_d = '0;
					phase_d        = PH_QNAME;
				end else begin
					field_offset_d = field_offset_q + 4'd1;
				end
			end
			PH_QNAME, PH_ANAME: begin
				if (b == 8'h00) begin
					phase_d        = is_question ? PH_QFIXED : PH_AFIXED;
					field_offset_d = '0;
				end else if ((b & PTR_MASK) == PTR_MASK) begin
					phase_d = is_question ? PH_QPTR : PH_APTR;
				end else begin
					skip_count_d = {8'h00, b};
					phase_d      = is_question ? PH_QLABEL : PH_ALABEL;
				end
			end
			PH_QLABEL: begin
				skip_count_d = skip_dec;
				if (skip_dec == 16'd0) phase_d = PH_QNAME;
			end
			PH_ALABEL: begin
				skip_count_d = skip_dec;
				if (skip_dec == 16'd0) phase_d = PH_ANAME;
			end
			PH_QPTR: begin
				phase_d        = PH_QFIXED;
				field_offset_d = '0;
			end
			PH_APTR: begin
				phase_d        = PH_AFIXED;
				field_offset_d = '0;
			end
			PH_QFIXED: begin
				if (field_offset_q == QFIXED_BYTES - 4'd1) begin
					field_offset_d = '0;
					phase_d        = (answers_left_q == 16'd0) ? PH_DONE : PH_ANAME;
				end else begin
					field_offset_d = field_offset_q + 4'd1;
				end
			end
			PH_AFIXED: begin
				case (field_offset_q)
					OFS_TYPE_HI: record_type_d     = {b, 8'h00};
					OFS_TYPE_LO: record_type_d     = record_type_q | {8'h00, b};
					OFS_RDL_HI:  record_length_new = {b, 8'h00};
					OFS_RDL_LO:  record_length_new = record_length_q | {8'h00, b};
					default: ;
				endcase
				record_length_d = record_length_new;
				if (field_offset_q == FIXED_BYTES - 4'd1) begin
					field_offset_d = '0;
					if (record_type_q == TYPE_A && record_length_new == ADDR_RDLENGTH) begin
						phase_d = PH_RADDR;
					end else if (record_length_new == 16'd0) begin
						// zero-length data: record ends here
						if (answers_left_q <= 16'd1) begin
							phase_d = PH_DONE;
						end else begin
							answers_left_d = answers_left_q - 16'd1;
							phase_d        = PH_ANAME;
						end
					end else begin
						skip_count_d = record_length_new;
						phase_d      = PH_RSKIP;
					end
				end else begin
					field_offset_d = field_offset_q + 4'd1;
				end
			end
			PH_RSKIP: begin
				skip_count_d = skip_dec;
				if (skip_dec == 16'd0) begin
					if (answers_left_q <= 16'd1) begin
						phase_d = PH_DONE;
					end else begin
						answers_left_d = answers_left_q - 16'd1;
						phase_d        = PH_ANAME;
					end
				end
			end
			PH_RADDR: begin
				address_shift_d = {address_shift_q[23:0], b};
				if (field_offset_q == ADDR_BYTES - 4'd1) begin
					field_offset_d = '0;
					found_d        = 1'b1;
					phase_d        = PH_DONE;
				end else begin
					field_offset_d = field_offset_q + 4'd1;
				end
			end
			default: ;
		endcase
	end

	// verdict at the last byte, taken from the updated state
	always_comb begin
		push.load            = fire && item_s1.last_byte;
		push.data.status     = ST_NO_ADDRESS;
		push.data.error_code = 4'd0;
		push.data.address    = 32'd0;
		if (phase_d == PH_HEADER) begin
			push.data.status = ST_IGNORED;
		end else if (header_id_d != expected_id || !header_flags_d[FLAG_QR_BIT]) begin
			push.data.status = ST_IGNORED;
		end else if (header_flags_d[3:0] != 4'd0) begin
			push.data.status     = ST_SERVER_ERR;
			push.data.error_code = header_flags_d[3:0];
		end else if (answers_left_d == 16'd0) begin
			push.data.status = ST_NO_ANSWERS;
		end else if (found_d) begin
			push.data.status  = ST_RESOLVED;
			push.data.address = address_shift_d;
		end
	end

	// parse state, cleared after each packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HEADER;
			field_offset_q  <= '0;
			header_id_q     <= '0;
			header_flags_q  <= '0;
			answers_left_q  <= '0;
			skip_count_q    <= '0;
			record_type_q   <= '0;
			record_length_q <= '0;
			address_shift_q <= '0;
			found_q         <= 1'b0;
		end else if (fire) begin
			if (item_s1.last_byte) begin
				phase_q         <= PH_HEADER;
				field_offset_q  <= '0;
				header_id_q     <= '0;
				header_flags_q  <= '0;
				answers_left_q  <= '0;
				skip_count_q    <= '0;
				record_type_q   <= '0;
				record_length_q <= '0;
				address_shift_q <= '0;
				found_q         <= 1'b0;
			end else begin
				phase_q         <= phase_d;
				field_offset_q  <= field_offset_d;
				header_id_q     <= header_id_d;
				header_flags_q  <= header_flags_d;
				answers_left_q  <= answers_left_d;
				skip_count_q    <= skip_count_d;
				record_type_q   <= record_type_d;
				record_length_q <= record_length_d;
				address_shift_q <= address_shift_d;
				found_q         <= found_d;
			end
		end
	end

endmodule : dnsrp_parser
`default_nettype wire

### rtl/core/dnsrp_result_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnsrp_result_reg
// Output register holding one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module dnsrp_result_reg import dnsrp_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire result_push_t push,
	input  wire logic         result_stall,
	output logic              result_valid,
	output result_t           result,
	output logic              free
);

	logic    valid_q;
	result_t data_q;

	// slot can take a new result this cycle
	assign free         = !valid_q || !result_stall;
	assign result_valid = valid_q;
	assign result       = data_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push.load) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (push.load) begin
			data_q <= push.data;
		end
	end

endmodule : dnsrp_result_reg
`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks dns_response_parser_unit with short directed packets, then random
// DNS responses (mostly well formed, some truncated, padded or pure noise).
// A per-byte parse model predicts one verdict per packet, and the verdicts
// are compared field by field. The run covers several expected-ID settings
// and several phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dnsrp_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int BYTES_PER_PHASE = 475;
	localparam int LATENCY_PAD = 4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;

	// feed of packet bytes and the verdicts still to come
	item_t       byte_feed[$];
	result_t     verdict_q[$];
	logic [7:0]  pkt[$];

	// parse model state
	phase_t      ps_phase;
	logic [3:0]  ps_ofs;
	logic [15:0] ps_id;
	logic [15:0] ps_flags;
	logic [15:0] ps_ans;
	logic [15:0] ps_skip;
	logic [15:0] ps_rtype;
	logic [15:0] ps_rlen;
	logic [31:0] ps_addr;
	logic        ps_found;
	logic [15:0] query_id = EXPECTED_ID_RESET;

	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          send_calm = 0;
	int          recv_calm = 0;
	bit          gap_now;
	bit          stall_now;
	int          fails = 0;
	int          quiet_cycles = 0;

	dns_response_parser_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------- model

	task automatic clear_parse();
		ps_phase = PH_HEADER;
		ps_ofs   = '0;
		ps_id    = '0;
		ps_flags = '0;
		ps_ans   = '0;
		ps_skip  = '0;
		ps_rtype = '0;
		ps_rlen  = '0;
		ps_addr  = '0;
		ps_found = 1'b0;
	endtask

	// record fully passed: next one or done
	task automatic close_record();
		if (ps_ans <= 16'd1) begin
			ps_phase = PH_DONE;
		end else begin
			ps_ans   = ps_ans - 16'd1;
			ps_phase = PH_ANAME;
		end
	endtask

	// first byte of a question or answer name
	task automatic name_start(input logic [7:0] b, input bit question);
		if (b == 8'h00) begin
			ps_ofs = '0;
			if (question) ps_phase = PH_QFIXED;
			else ps_phase = PH_AFIXED;
		end else if ((b & PTR_MASK) == PTR_MASK) begin
			if (question) ps_phase = PH_QPTR;
			else ps_phase = PH_APTR;
		end else begin
			ps_skip = {8'h00, b};
			if (question) ps_phase = PH_QLABEL;
			else ps_phase = PH_ALABEL;
		end
	endtask

	// advance the parse by one accepted byte, queue a verdict on the last one
	task automatic parse_byte(input item_t t);
		logic [7:0] b;
		result_t    v;
		b = t.packet_byte;
		case (ps_phase)
			PH_HEADER: begin
				case (ps_ofs)
					OFS_ID_HI:  ps_id = {b, 8'h00};
					OFS_ID_LO:  ps_id[7:0] = b;
					OFS_FLG_HI: ps_flags = {b, 8'h00};
					OFS_FLG_LO: ps_flags[7:0] = b;
					OFS_ANC_HI: ps_ans = {b, 8'h00};
					OFS_ANC_LO: ps_ans[7:0] = b;
					default: ;
				endcase
				ps_ofs = ps_ofs + 4'd1;
				if (ps_ofs >= HEADER_BYTES) begin
					ps_ofs   = '0;
					ps_phase = PH_QNAME;
				end
			end
			PH_QNAME: name_start(b, 1'b1);
			PH_ANAME: name_start(b, 1'b0);
			PH_QLABEL, PH_ALABEL: begin
				ps_skip = ps_skip - 16'd1;
				if (ps_skip == 16'd0) begin
					if (ps_phase == PH_QLABEL) ps_phase = PH_QNAME;
					else ps_phase = PH_ANAME;
				end
			end
			PH_QPTR: begin
				ps_phase = PH_QFIXED;
				ps_ofs   = '0;
			end
			PH_APTR: begin
				ps_phase = PH_AFIXED;
				ps_ofs   = '0;
			end
			PH_QFIXED: begin
				ps_ofs = ps_ofs + 4'd1;
				if (ps_ofs >= QFIXED_BYTES) begin
					ps_ofs = '0;
					if (ps_ans == 16'd0) ps_phase = PH_DONE;
					else ps_phase = PH_ANAME;
				end
			end
			PH_AFIXED: begin
				case (ps_ofs)
					OFS_TYPE_HI: ps_rtype = {b, 8'h00};
					OFS_TYPE_LO: ps_rtype[7:0] = b;
					OFS_RDL_HI:  ps_rlen = {b, 8'h00};
					OFS_RDL_LO:  ps_rlen[7:0] = b;
					default: ;
				endcase
				ps_ofs = ps_ofs + 4'd1;
				if (ps_ofs >= FIXED_BYTES) begin
					ps_ofs = '0;
					if (ps_rtype == TYPE_A && ps_rlen == ADDR_RDLENGTH) begin
						ps_phase = PH_RADDR;
					end else if (ps_rlen == 16'd0) begin
						close_record();
					end else begin
						ps_skip  = ps_rlen;
						ps_phase = PH_RSKIP;
					end
				end
			end
			PH_RSKIP: begin
				ps_skip = ps_skip - 16'd1;
				if (ps_skip == 16'd0) close_record();
			end
			PH_RADDR: begin
				ps_addr = {ps_addr[23:0], b};
				ps_ofs  = ps_ofs + 4'd1;
				if (ps_ofs >= ADDR_BYTES) begin
					ps_ofs   = '0;
					ps_found = 1'b1;
					ps_phase = PH_DONE;
				end
			end
			default: ;
		endcase

		// verdict in priority order
		if (t.last_byte) begin
			v = '0;
			if (ps_phase == PH_HEADER) begin
				v.status = ST_IGNORED;
			end else if (ps_id != query_id || !ps_flags[FLAG_QR_BIT]) begin
				v.status = ST_IGNORED;
			end else if (ps_flags[3:0] != 4'd0) begin
				v.status     = ST_SERVER_ERR;
				v.error_code = ps_flags[3:0];
			end else if (ps_ans == 16'd0) begin
				v.status = ST_NO_ANSWERS;
			end else if (ps_found) begin
				v.status  = ST_RESOLVED;
				v.address = ps_addr;
			end else begin
				v.status = ST_NO_ADDRESS;
			end
			verdict_q.push_back(v);
			clear_parse();
		end
	endtask

	// random gap with occasional stretches of none
	task automatic roll_gap(input int pct, inout int calm, output bit gap);
		if (calm > 0) begin
			calm = calm - 1;
			gap  = 1'b0;
		end else begin
			if ($urandom_range(63) == 0) calm = $urandom_range(40, 10);
			gap = ($urandom_range(99) < pct);
		end
	endtask

	// ------------------------------------------------------------ stimulus

	task automatic put16(input logic [15:0] v);
		pkt.push_back(v[15:8]);
		pkt.push_back(v[7:0]);
	endtask

	// label run, pointer, or label run closed by a pointer
	task automatic put_name();
		int pick;
		int n_lab;
		int len;
		pick = $urandom_range(9);
		if (pick >= 4) begin
			n_lab = $urandom_range(3, 1);
			repeat (n_lab) begin
				len = ($urandom_range(29) == 0) ? $urandom_range(70, 60) : $urandom_range(6, 1);
				pkt.push_back(8'(len));
				repeat (len) pkt.push_back(8'($urandom));
			end
		end
		if (pick < 4 || pick >= 8) begin
			pkt.push_back(PTR_MASK | 8'($urandom_range(63)));
			pkt.push_back(8'($urandom));
		end else begin
			pkt.push_back(8'h00);
		end
	endtask

	task automatic gen_packet();
		int          pick;
		int          n_ans;
		int          cut;
		logic [15:0] flags;
		logic [15:0] ancount;
		logic [15:0] rtype;
		logic [15:0] rlen;
		pkt.delete();
		pick = $urandom_range(99);
		// pure noise
		if (pick < 8) begin
			repeat ($urandom_range(40, 1)) pkt.push_back(8'($urandom));
			return;
		end
		// header
		put16((pick < 88) ? query_id : 16'($urandom));
		flags = 16'($urandom);
		flags[FLAG_QR_BIT] = ($urandom_range(9) != 0);
		if ($urandom_range(5) != 0) flags[3:0] = 4'd0;
		put16(flags);
		put16(16'($urandom));
		pick = $urandom_range(19);
		if (pick < 3) ancount = 16'd0;
		else if (pick == 3) ancount = 16'hFFFF;
		else if (pick == 4) ancount = 16'($urandom);
		else ancount = 16'($urandom_range(3, 1));
		put16(ancount);
		put16(16'($urandom));
		put16(16'($urandom));
		// question
		put_name();
		repeat (4) pkt.push_back(8'($urandom));
		// answer records
		n_ans = (ancount > 16'd3) ? $urandom_range(3, 1) : int'(ancount);
		repeat (n_ans) begin
			put_name();
			pick = $urandom_range(9);
			if (pick < 6) rtype = TYPE_A;
			else if (pick < 8) rtype = 16'd5;
			else rtype = 16'($urandom);
			pick = $urandom_range(29);
			if (pick == 0) rlen = 16'($urandom_range(300, 256));
			else if (rtype == TYPE_A && pick < 24) rlen = ADDR_RDLENGTH;
			else rlen = 16'($urandom_range(6));
			put16(rtype);
			repeat (6) pkt.push_back(8'($urandom));
			put16(rlen);
			repeat (int'(rlen)) pkt.push_back(8'($urandom));
		end
		// damage: truncate or pad
		pick = $urandom_range(99);
		if (pick < 12) begin
			cut = $urandom_range(pkt.size() - 1, 1);
			while (pkt.size() > cut) void'(pkt.pop_back());
		end else if (pick < 22) begin
			repeat ($urandom_range(8, 1)) pkt.push_back(8'($urandom));
		end
	endtask

	task automatic load_packet();
		item_t t;
		for (int i = 0; i < pkt.size(); i++) begin
			t.packet_byte = pkt[i];
			t.last_byte   = (i == pkt.size() - 1);
			byte_feed.push_back(t);
		end
	endtask

	// hold off until every verdict is in, then let the pipeline settle
	task automatic drain_results();
		while (byte_feed.size() != 0 || item_valid || verdict_q.size() != 0)
			@(negedge clk);
		repeat (LATENCY_PAD) @(negedge clk);
	endtask

	task automatic write_query_id(input logic [15:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		query_id = v;
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------- driver

	// present queued bytes, hold a stalled transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
		end else begin
			if (item_valid && !item_stall) parse_byte(item);
			if (!(item_valid && item_stall)) begin
				roll_gap(send_idle_pct, send_calm, gap_now);
				if (byte_feed.size() != 0 && !gap_now) begin
					item       <= byte_feed.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// --------------------------------------------------------------- monitor

	// compare each verdict transaction with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : verdict_check
		result_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (verdict_q.size() == 0) begin
					$display("%0t: unexpected verdict status=%0d code=%0d addr=%h",
						$time, result.status, result.error_code, result.address);
					fails++;
				end else begin
					want = verdict_q.pop_front();
					if (result.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, result.status);
						fails++;
					end
					if (result.error_code !== want.error_code) begin
						$display("%0t: error_code expected %0d actual %0d",
							$time, want.error_code, result.error_code);
						fails++;
					end
					if (result.address !== want.address) begin
						$display("%0t: address expected %h actual %h",
							$time, want.address, result.address);
						fails++;
					end
				end
			end
			roll_gap(stall_pct, recv_calm, stall_now);
			result_stall <= stall_now;
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("dns_response_parser_unit regression: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// -------------------------------------------------------------- sequence

	initial begin : run
		int          sent;
		int          n_pkts;
		int          idle_tab[4];
		int          stall_tab[4];
		logic [15:0] id_tab[4];
		idle_tab  = '{0, 60, 0, 21};
		stall_tab = '{0, 0, 60, 21};
		id_tab    = '{16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom)};
		clear_parse();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: one-byte packet, header one byte short, header-only error
		pkt.delete();
		pkt.push_back(8'hFF);
		load_packet();
		pkt.delete();
		put16(EXPECTED_ID_RESET);
		put16(16'h8000);
		put16(16'h0001);
		put16(16'h0001);
		put16(16'h0000);
		pkt.push_back(8'h00);
		load_packet();
		pkt.delete();
		put16(EXPECTED_ID_RESET);
		put16(16'h800F);
		put16(16'h0001);
		put16(16'h0001);
		put16(16'h0000);
		put16(16'h0000);
		load_packet();
		drain_results();

		// random phases, each with its own expected ID and idling mix
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_tab[p];
			stall_pct     = stall_tab[p];
			write_query_id(id_tab[p]);
			sent   = 0;
			n_pkts = 0;
			while (sent < BYTES_PER_PHASE) begin
				gen_packet();
				load_packet();
				sent   += pkt.size();
				n_pkts += 1;
				if (n_pkts == 1 || $urandom_range(15) == 0) drain_results();
			end
			drain_results();
		end

		if (fails == 0 && verdict_q.size() == 0) begin
			$display("dns_response_parser_unit regression: pass");
		end else begin
			$display("dns_response_parser_unit regression: fail");
		end
		$finish;
	end

endmodule
